[hw/rtl/lpt_pkg.sv]
package lpt_pkg;

    // Field and register widths
    localparam int FrameW  = 16;
    localparam int ErrW    = 9;
    localparam int RegW    = 16;
    localparam int StepW   = 9;
    localparam int MaxRuns = 8;

    // Direction bit positions
    localparam int DirLeft     = 0;
    localparam int DirStraight = 1;
    localparam int DirRight    = 2;

    // Junction and side thresholds
    localparam logic signed [ErrW-1:0] SideLimit     = 9'sd40;
    localparam logic signed [ErrW-1:0] StraightLimit = 9'sd90;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef enum logic [1:0] {
        STAT_NORMAL   = 2'd0,
        STAT_LOST     = 2'd1,
        STAT_JUNCTION = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_MAX_STEP      = 2'd0,
        REG_LOST_LIMIT    = 2'd1,
        REG_LEFT_DEFAULT  = 2'd2,
        REG_RIGHT_DEFAULT = 2'd3
    } t_reg_idx;

    // Control from the sequencer to the run scanner
    typedef struct packed {
        logic                   start;
        logic [FrameW-1:0]      bits;
        logic signed [ErrW-1:0] last;
    } t_scan_ctl;

    // Chosen run, valid while done is high and held until the next start
    typedef struct packed {
        logic                   done;
        logic signed [ErrW-1:0] target;
        logic [3:0]             run_start;
        logic [3:0]             run_end;
    } t_scan_res;

    // Error magnitude for twice the distance of a run center from 7.5
    function automatic logic [7:0] err_lut(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'd0;
            4'd1:    v = 8'd13;
            4'd2:    v = 8'd26;
            4'd3:    v = 8'd39;
            4'd4:    v = 8'd53;
            4'd5:    v = 8'd66;
            4'd6:    v = 8'd81;
            4'd7:    v = 8'd96;
            4'd8:    v = 8'd111;
            4'd9:    v = 8'd126;
            4'd10:   v = 8'd141;
            4'd11:   v = 8'd156;
            4'd12:   v = 8'd171;
            4'd13:   v = 8'd186;
            4'd14:   v = 8'd201;
            4'd15:   v = 8'd216;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/lpt_scan.sv]
module lpt_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpt_pkg::t_scan_ctl i_ctl,
    output lpt_pkg::t_scan_res o_res
);
    import lpt_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [FrameW:0]        r_bits;
    logic [4:0]             r_step;
    logic                   r_in_run;
    logic [3:0]             r_start;
    logic [3:0]             r_count;
    logic signed [ErrW-1:0] r_last;
    logic [9:0]             r_best_dist;
    logic signed [ErrW-1:0] r_best_err;
    logic [3:0]             r_best_start;
    logic [3:0]             r_best_end;

    logic                   w_bit;
    logic [3:0]             w_end;
    logic signed [5:0]      w_d2;
    logic [3:0]             w_idx;
    logic [7:0]             w_mag;
    logic signed [ErrW-1:0] w_err;
    logic signed [9:0]      w_diff;
    logic [9:0]             w_dist;
    logic                   w_close;
    logic                   w_take;

    // Current bit is the MSB of the shifting frame; a zero pad closes a run at bit 0
    assign w_bit = r_bits[FrameW];
    assign w_end = 4'(5'd16 - r_step);

    // Run center, table lookup and distance to the last error
    always_comb begin
        w_d2   = $signed({2'b00, r_start}) + $signed({2'b00, w_end}) - 6'sd15;
        w_idx  = (w_d2 < 0) ? 4'(-w_d2) : w_d2[3:0];
        w_mag  = err_lut(w_idx);
        w_err  = (w_d2 > 0) ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        w_diff = 10'(w_err) - 10'(r_last);
        w_dist = (w_diff < 0) ? 10'(-w_diff) : 10'(w_diff);
    end

    // A run closes on a zero; only the first eight runs count; first one wins ties
    assign w_close = r_busy && !w_bit && r_in_run && (r_count < 4'(MaxRuns));
    assign w_take  = w_close && ((r_count == 4'd0) || (w_dist < r_best_dist));

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_step == 5'd16)) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    // Bit walk and best-run tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 5'd0;
            r_in_run <= 1'b0;
            r_count  <= 4'd0;
        end else if (i_ctl.start) begin
            r_bits   <= {i_ctl.bits, 1'b0};
            r_step   <= 5'd0;
            r_in_run <= 1'b0;
            r_count  <= 4'd0;
            r_last   <= i_ctl.last;
        end else if (r_busy) begin
            r_bits <= {r_bits[FrameW-1:0], 1'b0};
            r_step <= r_step + 5'd1;
            if (w_bit && !r_in_run) begin
                r_in_run <= 1'b1;
                r_start  <= 4'(5'd15 - r_step);
            end
            if (!w_bit) begin
                r_in_run <= 1'b0;
            end
            if (w_close) begin
                r_count <= r_count + 4'd1;
            end
            if (w_take) begin
                r_best_dist  <= w_dist;
                r_best_err   <= w_err;
                r_best_start <= r_start;
                r_best_end   <= w_end;
            end
        end
    end

    assign o_res.done      = r_done;
    assign o_res.target    = r_best_err;
    assign o_res.run_start = r_best_start;
    assign o_res.run_end   = r_best_end;

    // Run count never passes the limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 4'(MaxRuns))
        else $error("run count beyond limit");

endmodule

[hw/rtl/line_position_tracker_core.sv]
// Channel   | Dir | Payload
// s_axis    | in  | tuser: mode; tdata: frame_bits[15:0], forced_error[24:16]
// m_axis    | out | tuser: status; tdata: directions, filtered, left, right errors
// i_cfg_*   | in  | write enable, register index, 16-bit data
//
// A force item is taken in idle and gives no transfer out.
// An empty frame skips the scanner and goes from idle straight to finish.
// A line frame walks 17 bit positions through one run scanner, one per cycle; the
// sequencer waits in scan for done, then registers the result in finish and returns to idle.
// Input ready is high only in idle; a stalled output holds the sequencer in finish.
// Synchronous active-low reset returns the configuration, state and tracking registers to their defaults.
module line_position_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // frame_bits[15:0], forced_error[24:16], zeros
    input  logic        s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // directions[2:0], filtered_error[18:3],
                                        // left_error[34:19], right_error[50:35], zeros
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import lpt_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [StepW-1:0]       r_max_step;
    logic [RegW-1:0]        r_lost_limit;
    logic [RegW-1:0]        r_left_def;
    logic [RegW-1:0]        r_right_def;
    logic [RegW-1:0]        r_lost;
    logic signed [ErrW-1:0] r_last;
    logic                   r_pending;
    logic                   r_empty;
    logic                   r_out_valid;
    t_status                r_out_status;
    logic [2:0]             r_out_dirs;
    logic [RegW-1:0]        r_out_filt;
    logic [RegW-1:0]        r_out_left;
    logic [RegW-1:0]        r_out_right;

    t_scan_ctl              w_ctl;
    t_scan_res              w_res;
    logic                   w_in_xfer;
    logic                   w_frame_empty;
    logic                   w_out_free;
    logic                   w_emit;
    logic signed [10:0]     w_delta;
    logic signed [10:0]     w_lim;
    logic signed [10:0]     w_step;
    logic signed [ErrW-1:0] w_new_last;
    logic [4:0]             w_width;
    logic [2:0]             w_dirs;
    logic [1:0]             w_ndir;
    t_status                w_status;
    logic [2:0]             w_dirs_out;
    logic [RegW-1:0]        w_filt;
    logic [RegW-1:0]        w_left;
    logic [RegW-1:0]        w_right;
    logic                   w_lost;

    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_frame_empty = (s_axis_tdata[FrameW-1:0] == '0);
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_xfer && !s_axis_tuser) begin
                    n_state = w_frame_empty ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_res.done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_ctl.start   = (r_state == ST_IDLE) && w_in_xfer && !s_axis_tuser && !w_frame_empty;
        w_ctl.bits    = s_axis_tdata[FrameW-1:0];
        w_ctl.last    = r_last;
        w_emit        = (r_state == ST_FINISH) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    lpt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_res   (w_res)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step   <= 9'd35;
            r_lost_limit <= 16'd2000;
            r_left_def   <= 16'hFF06;
            r_right_def  <= 16'd250;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MAX_STEP:      r_max_step   <= i_cfg_data[StepW-1:0];
                REG_LOST_LIMIT:    r_lost_limit <= i_cfg_data;
                REG_LEFT_DEFAULT:  r_left_def   <= i_cfg_data;
                REG_RIGHT_DEFAULT: r_right_def  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Rate limiter toward the chosen run; after a force the target is taken without limit
    always_comb begin
        w_delta = 11'(w_res.target) - 11'(r_last);
        w_lim   = $signed({2'b00, r_max_step});
        if (w_delta > w_lim) begin
            w_step = w_lim;
        end else if (w_delta < -w_lim) begin
            w_step = -w_lim;
        end else begin
            w_step = w_delta;
        end
        w_new_last = r_pending ? w_res.target : ErrW'(11'(r_last) + w_step);
    end

    // Junction directions from the chosen run
    always_comb begin
        w_width = {1'b0, w_res.run_start} - {1'b0, w_res.run_end};
        w_dirs  = 3'b000;
        if (w_width >= 5'd3) begin
            w_dirs[DirLeft]     = (w_res.run_start >= 4'd10);
            w_dirs[DirStraight] = (w_res.target < StraightLimit) &&
                                  (w_res.target > -StraightLimit);
            w_dirs[DirRight]    = (w_res.run_end <= 4'd5);
            if (w_width >= 5'd7) begin
                w_dirs = 3'b111;
            end
        end
        w_ndir = 2'(w_dirs[0]) + 2'(w_dirs[1]) + 2'(w_dirs[2]);
    end

    // Result fields
    always_comb begin
        w_lost = (r_lost >= r_lost_limit);
        if (r_empty) begin
            w_status   = w_lost ? STAT_LOST : STAT_NORMAL;
            w_dirs_out = 3'b000;
            w_filt     = !w_lost ? RegW'(r_last) : (r_last < 0) ? r_left_def : r_right_def;
            w_left     = r_left_def;
            w_right    = r_right_def;
        end else begin
            w_status   = (w_ndir >= 2'd2) ? STAT_JUNCTION : STAT_NORMAL;
            w_dirs_out = (w_ndir >= 2'd2) ? w_dirs : 3'b000;
            w_filt     = RegW'(w_new_last);
            w_left     = (w_res.target < -SideLimit) ? RegW'(w_res.target) : r_left_def;
            w_right    = (w_res.target > SideLimit) ? RegW'(w_res.target) : r_right_def;
        end
    end

    // Tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lost    <= '0;
            r_last    <= '0;
            r_pending <= 1'b0;
        end else if (w_in_xfer) begin
            if (s_axis_tuser) begin
                r_last    <= $signed(s_axis_tdata[FrameW+ErrW-1:FrameW]);
                r_pending <= 1'b1;
            end else if (w_frame_empty) begin
                if (r_lost < r_lost_limit) begin
                    r_lost <= r_lost + 16'd1;
                end
            end else begin
                r_lost <= '0;
            end
        end else if (w_emit && !r_empty) begin
            r_last    <= w_new_last;
            r_pending <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_empty <= w_frame_empty;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_status <= w_status;
            r_out_dirs   <= w_dirs_out;
            r_out_filt   <= w_filt;
            r_out_left   <= w_left;
            r_out_right  <= w_right;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {5'b00000, r_out_right, r_out_left, r_out_filt, r_out_dirs};

    // A sensor frame transfer closes the input until its result is produced
    a_frame_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !s_axis_tready)
        else $error("input reopened during frame processing");

    // Directions are zero unless a junction is reported
    a_dirs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_JUNCTION)) |-> (m_axis_tdata[2:0] == 3'b000))
        else $error("directions without junction");

    // A junction names at least two directions
    a_junction_dirs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == STAT_JUNCTION)) |->
            ($countones(m_axis_tdata[2:0]) >= 2))
        else $error("junction with fewer than two directions");

    // A force never produces a result
    a_force_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("result after force item");

endmodule
